// ===== rtl/core/sbcw_pkg.sv =====
// Shared codes and widths for the scaled byte column writer.
package sbcw_pkg;

	// Field widths fixed by the interface
	localparam int COL_W  = 7;
	localparam int PAGE_W = 3;
	localparam int BYTE_W = 8;
	localparam int SCL_W  = 3;

	// Command codes
	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Configuration register indexes
	localparam logic CFG_INVERT = 1'b0;
	localparam logic CFG_SCALE  = 1'b1;

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BUILD = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

endpackage

// ===== rtl/core/scaled_byte_column_writer.sv =====
// Scaled byte column writer: cursor, vertical stretch sequencer and write stream.
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+---------------------------
//  cmd     | cmd_valid cmd_ready command new_column          | set cursor / draw column
//          | new_page pixel_column                           |
//  wr      | wr_valid wr_ready write_column write_page       | display writes, last marks
//          | write_data last                                 | end of one command
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | invert, scale registers
//
// A set request completes in its acceptance cycle; cmd_ready stays high.
// A draw request holds cmd_ready low after acceptance: for each page row the single
// bit stretcher builds the byte one bit per cycle, then one write per cycle leaves
// through the output register, one per column of the stretched width, while wr_ready is high.
// A stall on wr holds the current write; cmd_ready is low until the last write is taken.
// Reset clears cursor to 0,0, invert to 0 and scale to 1. cfg_ready is always high.
module scaled_byte_column_writer
	import sbcw_pkg::*;
#(
	parameter int DISPLAY_WIDTH = 84,
	parameter int DISPLAY_PAGES = 6,
	parameter int MAX_SCALE     = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic              command,
	input  logic [7:0]        new_column,
	input  logic [3:0]        new_page,
	input  logic [BYTE_W-1:0] pixel_column,
	// write channel
	output logic              wr_valid,
	input  logic              wr_ready,
	output logic [COL_W-1:0]  write_column,
	output logic [PAGE_W-1:0] write_page,
	output logic [BYTE_W-1:0] write_data,
	output logic              last,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [SCL_W-1:0]  cfg_data
);

	localparam int CNT_W = (MAX_SCALE < 2) ? 1 : $clog2(MAX_SCALE + 1);

	logic [1:0]        state_q;
	logic              invert_q;
	logic [SCL_W-1:0]  scale_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [PAGE_W-1:0] cur_page_q;

	logic [COL_W-1:0]  base_col_q;
	logic [COL_W-1:0]  wcol_q;
	logic [PAGE_W-1:0] wpage_q;
	logic [BYTE_W-1:0] pix_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  rows_q;
	logic [CNT_W-1:0]  cols_q;
	logic [CNT_W-1:0]  row_q;
	logic [CNT_W-1:0]  colc_q;
	logic [2:0]        bit_q;
	logic [3:0]        src_q;
	logic [SCL_W-1:0]  rem_q;

	logic [SCL_W-1:0]  eff;
	logic [7:0]        eff8;
	logic [7:0]        col_room;
	logic [7:0]        page_room;
	logic [7:0]        cols_min;
	logic [7:0]        rows_min;
	logic [7:0]        next_sum;
	logic [7:0]        set_col_a;
	logic [7:0]        set_col;
	logic [3:0]        set_page_a;
	logic [3:0]        set_page;
	logic              bit_val;
	logic              rem_wrap;
	logic              last_col;
	logic              last_row;
	logic              cmd_acc;
	logic              wr_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign wr_acc  = wr_valid && wr_ready;

	// scale of 0 acts as 1, above the limit acts as the limit
	always_comb begin
		if (scale_q == '0) begin
			eff = SCL_W'(1);
		end else if ({1'b0, scale_q} > 4'(MAX_SCALE)) begin
			eff = SCL_W'(MAX_SCALE);
		end else begin
			eff = scale_q;
		end
	end

	assign eff8      = {5'd0, eff};
	assign col_room  = 8'(DISPLAY_WIDTH) - {1'b0, cur_col_q};
	assign page_room = 8'(DISPLAY_PAGES) - {5'd0, cur_page_q};
	assign cols_min  = (col_room < eff8) ? col_room : eff8;
	assign rows_min  = (page_room < eff8) ? page_room : eff8;
	assign next_sum  = {1'b0, cur_col_q} + eff8;

	// cursor set: one reduction, then saturate
	assign set_col_a  = (new_column >= 8'(DISPLAY_WIDTH)) ?
		new_column - 8'(DISPLAY_WIDTH) : new_column;
	assign set_col    = (set_col_a >= 8'(DISPLAY_WIDTH)) ? 8'(DISPLAY_WIDTH - 1) : set_col_a;
	assign set_page_a = (new_page >= 4'(DISPLAY_PAGES)) ?
		new_page - 4'(DISPLAY_PAGES) : new_page;
	assign set_page   = (set_page_a >= 4'(DISPLAY_PAGES)) ? 4'(DISPLAY_PAGES - 1) : set_page_a;

	// stretcher: source bit index advances every eff output bits
	assign bit_val  = (src_q < 4'd8) && pix_q[src_q[2:0]];
	assign rem_wrap = (SCL_W'(rem_q + SCL_W'(1)) == eff);

	assign last_col = (colc_q == CNT_W'(cols_q - 1'b1));
	assign last_row = (row_q == CNT_W'(rows_q - 1'b1));

	assign cmd_ready    = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign wr_valid     = (state_q == ST_EMIT);
	assign write_column = wcol_q;
	assign write_page   = wpage_q;
	assign write_data   = byte_q ^ {BYTE_W{invert_q}};
	assign last         = last_col && last_row;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			invert_q   <= 1'b0;
			scale_q    <= SCL_W'(1);
			cur_col_q  <= '0;
			cur_page_q <= '0;
			row_q      <= '0;
			colc_q     <= '0;
			bit_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_INVERT: invert_q <= cfg_data[0];
					CFG_SCALE:  scale_q  <= cfg_data;
					default:    ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (command == CMD_SET) begin
							cur_col_q  <= set_col[COL_W-1:0];
							cur_page_q <= set_page[PAGE_W-1:0];
						end else begin
							cur_col_q <= (next_sum >= 8'(DISPLAY_WIDTH)) ?
								'0 : next_sum[COL_W-1:0];
							row_q     <= '0;
							colc_q    <= '0;
							bit_q     <= '0;
							state_q   <= ST_BUILD;
						end
					end
				end
				ST_BUILD: begin
					bit_q <= 3'(bit_q + 3'd1);
					if (bit_q == 3'd7) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (wr_acc) begin
						if (!last_col) begin
							colc_q <= CNT_W'(colc_q + 1'b1);
						end else if (!last_row) begin
							colc_q  <= '0;
							row_q   <= CNT_W'(row_q + 1'b1);
							state_q <= ST_BUILD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && command == CMD_DRAW) begin
					pix_q      <= pixel_column;
					base_col_q <= cur_col_q;
					wcol_q     <= cur_col_q;
					wpage_q    <= cur_page_q;
					rows_q     <= rows_min[CNT_W-1:0];
					cols_q     <= cols_min[CNT_W-1:0];
					src_q      <= '0;
					rem_q      <= '0;
				end
			end
			ST_BUILD: begin
				byte_q <= {bit_val, byte_q[BYTE_W-1:1]};
				if (rem_wrap) begin
					rem_q <= '0;
					if (src_q < 4'd8) begin
						src_q <= 4'(src_q + 4'd1);
					end
				end else begin
					rem_q <= SCL_W'(rem_q + SCL_W'(1));
				end
			end
			ST_EMIT: begin
				if (wr_acc) begin
					if (!last_col) begin
						wcol_q <= COL_W'(wcol_q + 1'b1);
					end else begin
						wcol_q  <= base_col_q;
						wpage_q <= PAGE_W'(wpage_q + 1'b1);
					end
				end
			end
			default: ;
		endcase
	end

	a_no_cmd_while_writing: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && wr_valid))
		else $error("command accepted while writes pending");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> ({1'b0, write_column} < 8'(DISPLAY_WIDTH)))
		else $error("write column beyond right edge");

	a_page_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> ({5'd0, write_page} < 8'(DISPLAY_PAGES)))
		else $error("write page beyond bottom");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_acc && last) |=> cmd_ready)
		else $error("not ready after final write");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_col_q} < 8'(DISPLAY_WIDTH)) && ({5'd0, cur_page_q} < 8'(DISPLAY_PAGES)))
		else $error("cursor out of range");

endmodule
